FILE: sv/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 16;
    localparam int OP_W    = 3;
    localparam int BIT_W   = 4;
    localparam int CFG_A_W = 4;

    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_START   = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd2;
    localparam logic [OP_W-1:0] OP_RESTART = 3'd3;
    localparam logic [OP_W-1:0] OP_WRITE   = 3'd4;
    localparam logic [OP_W-1:0] OP_READ    = 3'd5;

    localparam logic [CFG_A_W-1:0] CFG_PHASE_DELAY    = 4'd0;
    localparam logic [CFG_A_W-1:0] CFG_STRETCH_ENABLE = 4'd1;
    localparam logic [CFG_A_W-1:0] CFG_TIMEOUT_ENABLE = 4'd2;
    localparam logic [CFG_A_W-1:0] CFG_STRETCH_LIMIT  = 4'd3;

    localparam logic [CNT_W-1:0] RST_PHASE_DELAY   = 16'd1;
    localparam logic             RST_STRETCH_EN    = 1'b1;
    localparam logic             RST_TIMEOUT_EN    = 1'b1;
    localparam logic [CNT_W-1:0] RST_STRETCH_LIMIT = 16'd1000;

    localparam logic [BIT_W-1:0] LAST_BIT = 4'd7;
    localparam logic [BIT_W-1:0] BIT_END  = 4'd8;

    typedef enum logic [22:0] {
        PH_IDLE       = 23'h000001,
        PH_ST_SDA_LOW = 23'h000002,
        PH_ST_SCL_LOW = 23'h000004,
        PH_SP_SDA_LOW = 23'h000008,
        PH_SP_SCL_REL = 23'h000010,
        PH_SP_SDA_REL = 23'h000020,
        PH_RS_SDA_REL = 23'h000040,
        PH_RS_SCL_REL = 23'h000080,
        PH_RS_SDA_LOW = 23'h000100,
        PH_RS_SCL_LOW = 23'h000200,
        PH_WR_SDA     = 23'h000400,
        PH_WR_SCL_REL = 23'h000800,
        PH_WR_SCL_LOW = 23'h001000,
        PH_WA_SDA_REL = 23'h002000,
        PH_WA_SCL_REL = 23'h004000,
        PH_WA_SAMPLE  = 23'h008000,
        PH_RD_SDA_REL = 23'h010000,
        PH_RD_SCL_REL = 23'h020000,
        PH_RD_SAMPLE  = 23'h040000,
        PH_RA_SDA     = 23'h080000,
        PH_RA_SCL_REL = 23'h100000,
        PH_RA_SCL_LOW = 23'h200000,
        PH_FINISH     = 23'h400000
    } t_phase;

    typedef struct packed {
        logic [CNT_W-1:0] phase_delay;
        logic             stretch_enable;
        logic             timeout_enable;
        logic [CNT_W-1:0] stretch_limit;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [BYTE_W-1:0] data_byte;
        logic              send_ack;
        logic              scl_level;
        logic              sda_level;
    } t_item;

    typedef struct packed {
        logic              scl_release;
        logic              sda_release;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_data;
        logic              ack_received;
        logic              stretch_timeout;
        logic              rejected;
    } t_res;

endpackage

FILE: sv/i2cm_engine.sv
// Bus phase machine: state, per-item next state and result.
`timescale 1ns / 1ps

module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_cfg  i_cfg,
    input  t_item i_item,
    output t_res  o_res
);

    t_phase            r_phase, n_phase, a_phase;
    logic [BIT_W-1:0]  r_bit, n_bit, a_bit;
    logic [BYTE_W-1:0] r_shift, n_shift, a_shift;
    logic [CNT_W-1:0]  r_delay, n_delay;
    logic [CNT_W-1:0]  r_stretch, n_stretch;
    logic              r_ack_choice, n_ack_choice;
    logic              r_ack_flag, n_ack_flag;
    logic              r_timeout, n_timeout;
    logic              r_scl, n_scl;
    logic              r_sda, n_sda;
    logic              r_scl_wait, n_scl_wait;
    logic [BYTE_W-1:0] r_last_read, n_last_read;

    logic is_cmd;
    logic idle;
    logic do_act;
    logic done;
    logic rej;
    logic [BYTE_W-1:0] rd_shift;

    assign idle     = (r_phase == PH_IDLE);
    assign rd_shift = {a_shift[BYTE_W-2:0], i_item.sda_level};

    always_comb begin
        is_cmd       = (i_item.opcode inside {[OP_START:OP_READ]});
        n_phase      = r_phase;
        n_bit        = r_bit;
        n_shift      = r_shift;
        n_delay      = r_delay;
        n_stretch    = r_stretch;
        n_ack_choice = r_ack_choice;
        n_ack_flag   = r_ack_flag;
        n_timeout    = r_timeout;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_scl_wait   = r_scl_wait;
        n_last_read  = r_last_read;
        a_phase      = r_phase;
        a_bit        = r_bit;
        a_shift      = r_shift;
        do_act       = 1'b0;
        done         = 1'b0;
        rej          = 1'b0;

        if (idle) begin
            if (is_cmd) begin
                n_timeout  = 1'b0;
                n_scl_wait = 1'b0;
                n_delay    = '0;
                a_bit      = '0;
                do_act     = 1'b1;
                case (i_item.opcode)
                    OP_START:   a_phase = PH_ST_SDA_LOW;
                    OP_STOP:    a_phase = PH_SP_SDA_LOW;
                    OP_RESTART: a_phase = PH_RS_SDA_REL;
                    OP_WRITE: begin
                        a_phase = PH_WR_SDA;
                        a_shift = i_item.data_byte;
                    end
                    default: begin
                        a_phase      = PH_RD_SDA_REL;
                        a_shift      = '0;
                        n_ack_choice = i_item.send_ack;
                    end
                endcase
                n_bit   = a_bit;
                n_shift = a_shift;
            end
        end else if (is_cmd) begin
            rej = 1'b1;
        end else if (r_scl_wait) begin
            if (i_item.scl_level) begin
                n_scl_wait = 1'b0;
                n_delay    = i_cfg.phase_delay;
            end else if (i_cfg.timeout_enable && (r_stretch == i_cfg.stretch_limit)) begin
                n_timeout  = 1'b1;
                n_scl_wait = 1'b0;
                n_delay    = i_cfg.phase_delay;
            end else begin
                n_stretch = r_stretch + 1'b1;
            end
        end else if (r_delay != '0) begin
            n_delay = r_delay - 1'b1;
        end else begin
            do_act = 1'b1;
        end

        if (do_act) begin
            n_phase = PH_FINISH;
            case (a_phase)
                PH_ST_SDA_LOW: begin
                    n_sda = 1'b0; n_phase = PH_ST_SCL_LOW; n_delay = i_cfg.phase_delay;
                end
                PH_ST_SCL_LOW: begin
                    n_scl = 1'b0; n_delay = i_cfg.phase_delay;
                end
                PH_SP_SDA_LOW: begin
                    n_sda = 1'b0; n_phase = PH_SP_SCL_REL; n_delay = i_cfg.phase_delay;
                end
                PH_SP_SCL_REL: n_phase = PH_SP_SDA_REL;
                PH_SP_SDA_REL: begin
                    n_sda = 1'b1; n_delay = i_cfg.phase_delay;
                end
                PH_RS_SDA_REL: begin
                    n_sda = 1'b1; n_phase = PH_RS_SCL_REL; n_delay = i_cfg.phase_delay;
                end
                PH_RS_SCL_REL: n_phase = PH_RS_SDA_LOW;
                PH_RS_SDA_LOW: begin
                    n_sda = 1'b0; n_phase = PH_RS_SCL_LOW; n_delay = i_cfg.phase_delay;
                end
                PH_RS_SCL_LOW: begin
                    n_scl = 1'b0; n_delay = i_cfg.phase_delay;
                end
                PH_WR_SDA: begin
                    n_sda   = a_shift[BYTE_W-1];
                    n_shift = {a_shift[BYTE_W-2:0], 1'b0};
                    n_phase = PH_WR_SCL_REL;
                    n_delay = i_cfg.phase_delay;
                end
                PH_WR_SCL_REL: n_phase = PH_WR_SCL_LOW;
                PH_WR_SCL_LOW: begin
                    n_scl   = 1'b0;
                    n_phase = (a_bit >= LAST_BIT) ? PH_WA_SDA_REL : PH_WR_SDA;
                    n_bit   = a_bit + 1'b1;
                    n_delay = i_cfg.phase_delay;
                end
                PH_WA_SDA_REL: begin
                    n_sda = 1'b1; n_phase = PH_WA_SCL_REL; n_delay = i_cfg.phase_delay;
                end
                PH_WA_SCL_REL: n_phase = PH_WA_SAMPLE;
                PH_WA_SAMPLE: begin
                    n_ack_flag = ~i_item.sda_level;
                    n_scl      = 1'b0;
                    n_delay    = i_cfg.phase_delay;
                end
                PH_RD_SDA_REL: begin
                    n_sda = 1'b1; n_phase = PH_RD_SCL_REL; n_delay = i_cfg.phase_delay;
                end
                PH_RD_SCL_REL: n_phase = PH_RD_SAMPLE;
                PH_RD_SAMPLE: begin
                    n_shift = rd_shift;
                    n_scl   = 1'b0;
                    if (a_bit >= LAST_BIT) begin
                        n_last_read = rd_shift;
                        n_phase     = PH_RA_SDA;
                    end else begin
                        n_phase = PH_RD_SCL_REL;
                    end
                    n_bit   = a_bit + 1'b1;
                    n_delay = i_cfg.phase_delay;
                end
                PH_RA_SDA: begin
                    n_sda   = ~r_ack_choice;
                    n_phase = PH_RA_SCL_REL;
                    n_delay = i_cfg.phase_delay;
                end
                PH_RA_SCL_REL: n_phase = PH_RA_SCL_LOW;
                PH_RA_SCL_LOW: begin
                    n_scl = 1'b0; n_delay = i_cfg.phase_delay;
                end
                PH_FINISH: begin
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end
                default: n_phase = PH_IDLE;
            endcase

            // SCL release: wait for the line when stretching is allowed
            if (a_phase inside {PH_SP_SCL_REL, PH_RS_SCL_REL, PH_WR_SCL_REL,
                                PH_WA_SCL_REL, PH_RD_SCL_REL, PH_RA_SCL_REL}) begin
                n_scl = 1'b1;
                if (i_cfg.stretch_enable) begin
                    n_scl_wait = 1'b1;
                    n_stretch  = '0;
                end else begin
                    n_delay = i_cfg.phase_delay;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit        <= '0;
            r_shift      <= '0;
            r_delay      <= '0;
            r_stretch    <= '0;
            r_ack_choice <= 1'b1;
            r_ack_flag   <= 1'b0;
            r_timeout    <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_scl_wait   <= 1'b0;
            r_last_read  <= '0;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_bit        <= n_bit;
            r_shift      <= n_shift;
            r_delay      <= n_delay;
            r_stretch    <= n_stretch;
            r_ack_choice <= n_ack_choice;
            r_ack_flag   <= n_ack_flag;
            r_timeout    <= n_timeout;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_scl_wait   <= n_scl_wait;
            r_last_read  <= n_last_read;
        end
    end

    assign o_res.scl_release     = n_scl;
    assign o_res.sda_release     = n_sda;
    assign o_res.busy_res        = (n_phase != PH_IDLE);
    assign o_res.done_res        = done;
    assign o_res.read_data       = n_last_read;
    assign o_res.ack_received    = n_ack_flag;
    assign o_res.stretch_timeout = n_timeout;
    assign o_res.rejected        = rej;

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && rej) |=> ($stable(r_phase) && $stable(r_delay) && $stable(r_scl_wait)))
        else $error("rejected command changed engine state");

    a_done_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.done_res |-> (r_phase == PH_FINISH))
        else $error("done outside finish phase");

    a_wait_scl_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scl_wait |-> r_scl)
        else $error("stretch wait while driving SCL low");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= BIT_END)
        else $error("bit index past ninth clock");

endmodule

FILE: sv/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: channels, config registers, result register.
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------------
//  cfg     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//  in      | i_in_valid  / o_in_ready   | opcode, data_byte, send_ack, scl/sda level
//  out     | o_out_valid / i_out_ready  | scl/sda release, busy, done, read_data, flags
//
// One item per cycle while the output is not stalled: an input register feeds the
// phase machine, whose result is registered in the output register when the input
// register fires, so an item passes through both registers before its output transfer.
// Each transfer yields exactly one result; the input register takes one more item
// while a result waits, then holds until the output register drains.
// Reset is synchronous; config, valid flags and engine state reset (lines released); item and result data do not.
// Config writes are always taken and registered; the engine reads them directly, also in a wait in progress.
`timescale 1ns / 1ps

module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_A_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]   i_cfg_data,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [OP_W-1:0]    i_opcode,
    input  logic [BYTE_W-1:0]  i_data_byte,
    input  logic               i_send_ack,
    input  logic               i_scl_level,
    input  logic               i_sda_level,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_scl_release,
    output logic               o_sda_release,
    output logic               o_busy_res,
    output logic               o_done_res,
    output logic [BYTE_W-1:0]  o_read_data,
    output logic               o_ack_received,
    output logic               o_stretch_timeout,
    output logic               o_rejected
);

    t_cfg  r_cfg;
    t_item r_in;
    logic  r_in_valid;
    t_res  r_res;
    logic  r_out_valid;
    t_res  n_res;
    logic  fire;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_delay    <= RST_PHASE_DELAY;
            r_cfg.stretch_enable <= RST_STRETCH_EN;
            r_cfg.timeout_enable <= RST_TIMEOUT_EN;
            r_cfg.stretch_limit  <= RST_STRETCH_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PHASE_DELAY:    r_cfg.phase_delay    <= i_cfg_data;
                CFG_STRETCH_ENABLE: r_cfg.stretch_enable <= i_cfg_data[0];
                CFG_TIMEOUT_ENABLE: r_cfg.timeout_enable <= i_cfg_data[0];
                CFG_STRETCH_LIMIT:  r_cfg.stretch_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.opcode    <= i_opcode;
            r_in.data_byte <= i_data_byte;
            r_in.send_ack  <= i_send_ack;
            r_in.scl_level <= i_scl_level;
            r_in.sda_level <= i_sda_level;
        end
    end

    i2cm_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (fire),
        .i_cfg   (r_cfg),
        .i_item  (r_in),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_scl_release     = r_res.scl_release;
    assign o_sda_release     = r_res.sda_release;
    assign o_busy_res        = r_res.busy_res;
    assign o_done_res        = r_res.done_res;
    assign o_read_data       = r_res.read_data;
    assign o_ack_received    = r_res.ack_received;
    assign o_stretch_timeout = r_res.stretch_timeout;
    assign o_rejected        = r_res.rejected;

endmodule
